// ----- src/kst_pkg.sv -----
package kst_pkg;

    localparam int KST_ENTRIES = 32;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 8;
    localparam int DEFAULT_W = 7;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_STORE  = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 2'd0,
        ST_INSERT = 2'd1,
        ST_MISS   = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

endpackage

// ----- src/keyed_setting_table.sv -----
// keyed_setting_table: small associative table of per-key 8-bit settings
//
// s_axis carries one request per transfer: tuser holds the operation
// (store, lookup, delete), tdata holds the 64-bit key and the value.
// m_axis returns exactly one result per request: tuser holds the status
// (hit, inserted, miss, full), tdata holds the lookup value and the slot.
// cfg_valid/cfg_data write the 7-bit default returned by a lookup miss;
// cfg_ready is always high.
//
// each request scans every slot of the key/value memory, one read per
// cycle through its single synchronous read port; a store then writes
// back at most once. a new request is taken only in the idle state, after
// the previous one has passed its scan and finish states.
// a finished result waits in the output register while the next request
// is accepted and scanned; the write-back and result load hold off while
// the receiver stalls with the output register still full.
// reset clears all valid marks at once, the default value and the output;
// key 0 never matches and never changes the table.
module keyed_setting_table #(
    parameter int ENTRIES = kst_pkg::KST_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // key[63:0], value[71:64]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // value_out[7:0], slot[12:8], zero[15:13]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_W = kst_pkg::KEY_W;
    localparam int VAL_W = kst_pkg::VALUE_W;
    localparam int MEM_W = KEY_W + VAL_W;

    kst_pkg::state_t state_reg, state_next;

    logic [MEM_W-1:0] mem [ENTRIES];
    logic [MEM_W-1:0] rdata_reg;
    logic             mem_rd;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [MEM_W-1:0] mem_wd;

    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic [kst_pkg::DEFAULT_W-1:0] default_reg;

    kst_pkg::func_t   func_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    logic             match_reg, match_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic [VAL_W-1:0] match_val_reg, match_val_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic                      out_valid_reg, out_valid_next;
    kst_pkg::status_t          out_status_reg, out_status_next;
    logic [VAL_W-1:0]          out_value_reg, out_value_next;
    logic [kst_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;

    logic             in_xfer;
    logic             proceed;
    logic             scan_done;
    logic             key_nz;
    logic             hit_now;
    logic             load_out;
    logic [IDX_W-1:0] fin_idx;
    logic [IDX_W+4:0] slot_ext;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign proceed   = !out_valid_reg || m_axis_tready;
    assign scan_done = (rd_cnt_reg == CNT_W'(ENTRIES));
    assign key_nz    = (key_reg != '0);
    assign hit_now   = pend_reg && valid_reg[pend_idx_reg] && key_nz
                       && (rdata_reg[KEY_W-1:0] == key_reg);
    assign fin_idx   = match_reg ? match_idx_reg : free_idx_reg;
    assign slot_ext  = {5'd0, fin_idx};

    assign s_axis_tready = (state_reg == kst_pkg::S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'd0, out_slot_reg, out_value_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kst_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = kst_pkg::S_SCAN;
                end
            end
            kst_pkg::S_SCAN:
            begin
                if (scan_done && pend_reg)
                begin
                    state_next = kst_pkg::S_FINISH;
                end
            end
            kst_pkg::S_FINISH:
            begin
                if (proceed)
                begin
                    state_next = kst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kst_pkg::S_IDLE;
            end
        endcase
    end

    // scan, write-back and result
    always_comb
    begin
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        match_val_next  = match_val_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        mem_rd          = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = fin_idx;
        mem_wd          = {value_reg, key_reg};
        load_out        = 1'b0;
        out_status_next = kst_pkg::ST_MISS;
        out_value_next  = '0;
        out_slot_next   = '0;

        case (state_reg)
            kst_pkg::S_IDLE:
            begin
                rd_cnt_next = '0;
                match_next  = 1'b0;
                free_next   = 1'b0;
            end
            kst_pkg::S_SCAN:
            begin
                if (!scan_done)
                begin
                    mem_rd        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                end
                if (hit_now && !match_reg)
                begin
                    match_next     = 1'b1;
                    match_idx_next = pend_idx_reg;
                    match_val_next = rdata_reg[MEM_W-1:KEY_W];
                end
                if (pend_reg && !valid_reg[pend_idx_reg] && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = pend_idx_reg;
                end
            end
            kst_pkg::S_FINISH:
            begin
                load_out = proceed;
                case (func_reg)
                    kst_pkg::FUNC_STORE:
                    begin
                        if (!key_nz)
                        begin
                            out_status_next = kst_pkg::ST_MISS;
                        end
                        else if (match_reg)
                        begin
                            mem_we          = proceed;
                            out_status_next = kst_pkg::ST_HIT;
                            out_slot_next   = slot_ext[4:0];
                        end
                        else if (free_reg)
                        begin
                            mem_we          = proceed;
                            if (proceed)
                            begin
                                valid_next[free_idx_reg] = 1'b1;
                            end
                            out_status_next = kst_pkg::ST_INSERT;
                            out_slot_next   = slot_ext[4:0];
                        end
                        else
                        begin
                            out_status_next = kst_pkg::ST_FULL;
                        end
                    end
                    kst_pkg::FUNC_LOOKUP:
                    begin
                        if (match_reg)
                        begin
                            out_status_next = kst_pkg::ST_HIT;
                            out_value_next  = match_val_reg;
                            out_slot_next   = slot_ext[4:0];
                        end
                        else
                        begin
                            out_value_next = {1'b0, default_reg};
                        end
                    end
                    kst_pkg::FUNC_DELETE:
                    begin
                        if (match_reg)
                        begin
                            if (proceed)
                            begin
                                valid_next[match_idx_reg] = 1'b0;
                            end
                            out_status_next = kst_pkg::ST_HIT;
                            out_slot_next   = slot_ext[4:0];
                        end
                    end
                    default:
                    begin
                        out_status_next = kst_pkg::ST_MISS;
                    end
                endcase
            end
            default:
            begin
                rd_cnt_next = '0;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kst_pkg::S_IDLE;
            valid_reg     <= '0;
            default_reg   <= '0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            match_reg     <= match_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                default_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg  <= kst_pkg::func_t'(s_axis_tuser);
            key_reg   <= s_axis_tdata[KEY_W-1:0];
            value_reg <= s_axis_tdata[MEM_W-1:KEY_W];
        end
        pend_idx_reg  <= pend_idx_next;
        match_idx_reg <= match_idx_next;
        match_val_reg <= match_val_next;
        free_idx_reg  <= free_idx_next;
        if (load_out)
        begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_slot_reg   <= out_slot_next;
        end
    end

    // key/value memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_rd)
        begin
            rdata_reg <= mem[rd_cnt_reg[IDX_W-1:0]];
        end
    end

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == kst_pkg::S_SCAN))
        else $error("compare pending outside scan");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CNT_W'(ENTRIES))
        else $error("scan counter past table end");

    a_match_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (match_reg && state_reg != kst_pkg::S_IDLE) |-> key_nz)
        else $error("reserved key matched");

    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kst_pkg::S_FINISH && proceed && func_reg == kst_pkg::FUNC_STORE
         && key_nz && !match_reg && free_reg) |=> valid_reg[$past(free_idx_reg)])
        else $error("inserted slot not marked valid");

    a_free_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kst_pkg::S_FINISH && free_reg) |-> !valid_reg[free_idx_reg])
        else $error("free slot already valid");

endmodule

// ----- sim/keyed_setting_table_tb.sv -----
module keyed_setting_table_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int KEY_POOL    = 40;
    localparam int TAIL_CYCLES = kst_pkg::KST_ENTRIES + 8;

    typedef struct {
        kst_pkg::status_t status;
        logic [7:0]       value_out;
        logic [4:0]       slot;
    } answer_t;

    // shadow copy of the table; predicts one answer per request
    class setting_table_shadow;
        bit          used [kst_pkg::KST_ENTRIES];
        logic [63:0] keys [kst_pkg::KST_ENTRIES];
        logic [7:0]  vals [kst_pkg::KST_ENTRIES];
        logic [6:0]  dflt;
        answer_t     answers [$];
        int          errors;
        int          tally [4];

        function void clear();
            for (int i = 0; i < kst_pkg::KST_ENTRIES; i++)
            begin
                used[i] = 1'b0;
                keys[i] = '0;
                vals[i] = '0;
            end
            dflt = '0;
            errors = 0;
            for (int i = 0; i < 4; i++)
                tally[i] = 0;
        endfunction

        function void set_default(logic [6:0] d);
            dflt = d;
        endfunction

        function int find_key(logic [63:0] k);
            if (k == '0)
                return kst_pkg::KST_ENTRIES;
            for (int i = 0; i < kst_pkg::KST_ENTRIES; i++)
                if (used[i] && keys[i] == k)
                    return i;
            return kst_pkg::KST_ENTRIES;
        endfunction

        function int free_slot();
            for (int i = 0; i < kst_pkg::KST_ENTRIES; i++)
                if (!used[i])
                    return i;
            return kst_pkg::KST_ENTRIES;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        function void take_request(kst_pkg::func_t f, logic [63:0] k, logic [7:0] v);
            answer_t a;
            int      hit;
            int      fr;
            a.status = kst_pkg::ST_MISS;
            a.value_out = '0;
            a.slot = '0;
            hit = find_key(k);
            case (f)
                kst_pkg::FUNC_STORE:
                    if (k != '0)
                    begin
                        if (hit < kst_pkg::KST_ENTRIES)
                        begin
                            vals[hit] = v;
                            a.status = kst_pkg::ST_HIT;
                            a.slot = 5'(hit);
                        end
                        else
                        begin
                            fr = free_slot();
                            if (fr < kst_pkg::KST_ENTRIES)
                            begin
                                used[fr] = 1'b1;
                                keys[fr] = k;
                                vals[fr] = v;
                                a.status = kst_pkg::ST_INSERT;
                                a.slot = 5'(fr);
                            end
                            else
                                a.status = kst_pkg::ST_FULL;
                        end
                    end
                kst_pkg::FUNC_LOOKUP:
                    if (hit < kst_pkg::KST_ENTRIES)
                    begin
                        a.status = kst_pkg::ST_HIT;
                        a.value_out = vals[hit];
                        a.slot = 5'(hit);
                    end
                    else
                        a.value_out = {1'b0, dflt};
                kst_pkg::FUNC_DELETE:
                    if (hit < kst_pkg::KST_ENTRIES)
                    begin
                        used[hit] = 1'b0;
                        a.status = kst_pkg::ST_HIT;
                        a.slot = 5'(hit);
                    end
                default:
                    ;
            endcase
            answers.push_back(a);
        endfunction

        function void match_answer(logic [1:0] st, logic [7:0] vo, logic [4:0] sl);
            answer_t a;
            if (answers.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            a = answers.pop_front();
            tally[a.status]++;
            if (st !== a.status)
            begin
                $error("status: expected %0d, got %0d", a.status, st);
                errors++;
            end
            if (vo !== a.value_out)
            begin
                $error("value_out: expected %0d, got %0d", a.value_out, vo);
                errors++;
            end
            if (sl !== a.slot)
            begin
                $error("slot: expected %0d, got %0d", a.slot, sl);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;

    setting_table_shadow shadow;
    logic [63:0] key_pool [KEY_POOL];
    int src_idle = 0;
    int sink_idle = 0;
    int hold_req = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int sent = 0;

    keyed_setting_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver side, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end

    // transfer monitor on both streams
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                shadow.match_answer(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8]);
            if (s_axis_tvalid && s_axis_tready)
                shadow.take_request(kst_pkg::func_t'(s_axis_tuser), s_axis_tdata[63:0],
                                    s_axis_tdata[71:64]);
        end
    end

    task automatic send_request(kst_pkg::func_t f, logic [63:0] k, logic [7:0] v);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f;
        s_axis_tdata <= {v, k};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_random();
        int             r;
        int             kr;
        kst_pkg::func_t f;
        logic [63:0]    k;
        r = $urandom_range(99);
        kr = $urandom_range(99);
        if (r < 45)
            f = kst_pkg::FUNC_STORE;
        else if (r < 75)
            f = kst_pkg::FUNC_LOOKUP;
        else if (r < 93)
            f = kst_pkg::FUNC_DELETE;
        else
            f = kst_pkg::FUNC_NONE;
        if (kr < 80)
            k = key_pool[$urandom_range(KEY_POOL-1)];
        else if (kr < 90)
            k = key_pool[$urandom_range(KEY_POOL-1)] ^ (64'h1 << $urandom_range(63));
        else if (kr < 95)
            k = {$urandom, $urandom};
        else
            k = '0;
        send_request(f, k, 8'($urandom_range(255)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_default(logic [6:0] d);
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow.set_default(d);
    endtask

    task automatic run_random(int count, int src_pct, int sink_pct);
        src_idle = src_pct;
        sink_idle = sink_pct;
        for (int i = 0; i < count; i++)
            send_random();
    endtask

    initial
    begin
        shadow = new();
        shadow.clear();
        key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[1] = 64'h1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        for (int i = 3; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reserved key, unused selector, insert/update/delete paths
        write_default(7'd100);
        src_idle = 0;
        sink_idle = 30;
        send_request(kst_pkg::FUNC_LOOKUP, 64'h0, 8'h00);
        send_request(kst_pkg::FUNC_STORE, 64'h0, 8'd55);
        send_request(kst_pkg::FUNC_DELETE, 64'h0, 8'hFF);
        send_request(kst_pkg::FUNC_NONE, key_pool[3], 8'hFF);
        send_request(kst_pkg::FUNC_LOOKUP, key_pool[0], 8'h00);
        send_request(kst_pkg::FUNC_STORE, key_pool[0], 8'hFF);
        send_request(kst_pkg::FUNC_STORE, key_pool[1], 8'h00);
        send_request(kst_pkg::FUNC_STORE, key_pool[2], 8'h80);
        send_request(kst_pkg::FUNC_LOOKUP, key_pool[0], 8'h00);
        send_request(kst_pkg::FUNC_STORE, key_pool[0], 8'h5A);
        send_request(kst_pkg::FUNC_LOOKUP, key_pool[0], 8'hA5);
        send_request(kst_pkg::FUNC_LOOKUP, key_pool[1] ^ 64'h2, 8'h00);
        send_request(kst_pkg::FUNC_LOOKUP, key_pool[2] ^ 64'h1, 8'h00);
        send_request(kst_pkg::FUNC_DELETE, key_pool[1], 8'h00);
        send_request(kst_pkg::FUNC_DELETE, key_pool[1], 8'h00);
        send_request(kst_pkg::FUNC_LOOKUP, key_pool[1], 8'h00);
        send_request(kst_pkg::FUNC_STORE, key_pool[3], 8'h07);
        send_request(kst_pkg::FUNC_NONE, key_pool[0], 8'h00);
        send_request(kst_pkg::FUNC_LOOKUP, key_pool[2], 8'h00);
        send_request(kst_pkg::FUNC_STORE, 64'h0, 8'hFF);
        send_request(kst_pkg::FUNC_LOOKUP, key_pool[3], 8'h00);
        drain();

        // sender seldom idle, receiver often stalls; pause halfway
        write_default(7'h7F);
        run_random(100, 7, 58);
        drain();
        run_random(100, 7, 58);
        drain();

        // roles swapped
        write_default(7'h00);
        run_random(200, 58, 7);
        drain();

        // long receiver hold-off while requests keep coming
        write_default(7'($urandom_range(127)));
        src_idle = 0;
        sink_idle = 0;
        @(negedge clk);
        hold_req = 400;
        @(posedge clk);
        run_random(30, 0, 0);
        drain();

        // no idling on either side
        write_default(7'($urandom_range(127)));
        run_random(150, 0, 0);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("ran %0d requests over several default values: %0d hits, %0d inserts,",
                 sent, shadow.tally[kst_pkg::ST_HIT], shadow.tally[kst_pkg::ST_INSERT]);
        $display("%0d misses and %0d full-table drops, with stalls and a long hold-off",
                 shadow.tally[kst_pkg::ST_MISS], shadow.tally[kst_pkg::ST_FULL]);
        if (shadow.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
